// ===== rtl/odo_pkg.sv =====
// ----------------------------------------------------------------------------
// odo_pkg - shared types, constants and helpers for the odometry block
// Fixed-point constants, action and register codes, CORDIC arctangent table.
// ----------------------------------------------------------------------------
package odo_pkg;

  localparam int CORDIC_STAGES_DEF = 24;

  // Q3.29 angles
  localparam logic signed [33:0] PI_Q29      = 34'sd1686629713;
  localparam logic signed [33:0] TWO_PI_Q29  = 34'sd3373259426;
  localparam logic signed [33:0] HALF_PI_Q29 = 34'sd843314857;
  // Q2.30 start vector, pre-scaled by the CORDIC gain
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  // pi/180 in Q0.32
  localparam logic signed [32:0] DEG_TO_RAD  = 33'sd74961321;

  localparam logic [22:0] TRACK_WIDTH_RST = 23'd786432;
  localparam logic [31:0] DIST_TICK_RST   = 32'd42824582;
  localparam logic [15:0] MIN_IVAL_RST    = 16'd3;

  typedef enum logic [2:0] {
    ACT_UPDATE  = 3'd0,
    ACT_SET_XY  = 3'd1,
    ACT_SET_HD  = 3'd2,
    ACT_CLR_XY  = 3'd3,
    ACT_INIT    = 3'd4,
    ACT_RESTART = 3'd5
  } action_t;

  localparam logic [1:0] CFG_TRACK_WIDTH = 2'd0;
  localparam logic [1:0] CFG_DIST_TICK   = 2'd1;
  localparam logic [1:0] CFG_MIN_IVAL    = 2'd2;

  // atan(2^-i) in Q2.30
  function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
    logic signed [33:0] v;
    unique case (i)
      5'd0:  v = 34'sd843314857;
      5'd1:  v = 34'sd497837829;
      5'd2:  v = 34'sd263043837;
      5'd3:  v = 34'sd133525159;
      5'd4:  v = 34'sd67021687;
      5'd5:  v = 34'sd33543516;
      5'd6:  v = 34'sd16775851;
      5'd7:  v = 34'sd8388437;
      5'd8:  v = 34'sd4194283;
      5'd9:  v = 34'sd2097149;
      5'd31: v = 34'sd0;
      default: v = 34'sd1 <<< (5'd30 - i);
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
    logic signed [31:0] r;
    if (v > 68'sd2147483647)       r = 32'sh7fffffff;
    else if (v < -68'sd2147483648) r = 32'sh80000000;
    else                           r = v[31:0];
    return r;
  endfunction

  // one wrap into plus or minus pi
  function automatic logic signed [31:0] wrap_pi(input logic signed [33:0] t);
    logic signed [33:0] w;
    if (t > PI_Q29)       w = t - TWO_PI_Q29;
    else if (t < -PI_Q29) w = t + TWO_PI_Q29;
    else                  w = t;
    return w[31:0];
  endfunction

endpackage

// ===== rtl/odo_div.sv =====
// ----------------------------------------------------------------------------
// odo_div - iterative signed divider
// Restoring division on magnitudes, one quotient bit per cycle, truncation
// toward zero, quotient saturated to 32 bits.
// ----------------------------------------------------------------------------
module odo_div
  import odo_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [63:0] num,
  input  logic signed [35:0] den,
  output logic               busy,
  output logic               done,
  output logic signed [31:0] quot
);

  localparam int NBITS = 63;

  logic [34:0] dmag;
  logic [35:0] rem;
  logic [62:0] nq;
  logic [5:0]  cnt;
  logic        neg;
  logic [35:0] trial;
  logic        fits;

  logic [63:0] num_abs;
  logic [35:0] den_abs;

  assign num_abs = num[63] ? 64'(-num) : 64'(num);
  assign den_abs = den[35] ? 36'(-den) : 36'(den);
  assign trial   = {rem[34:0], nq[62]};
  assign fits    = trial >= {1'b0, dmag};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !start && busy && (cnt == 6'(NBITS - 1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        nq   <= num_abs[62:0];
        dmag <= den_abs[34:0];
        neg  <= num[63] ^ den[35];
      end else if (busy) begin
        rem <= fits ? trial - {1'b0, dmag} : trial;
        nq  <= {nq[61:0], fits};
        cnt <= cnt + 6'd1;
        if (cnt == 6'(NBITS - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_comb begin
    if (neg) begin
      if (nq > 63'd2147483648) quot = 32'sh80000000;
      else                     quot = 32'(-nq[31:0]);
    end else begin
      if (nq > 63'd2147483647) quot = 32'sh7fffffff;
      else                     quot = nq[31:0];
    end
  end

endmodule

// ===== rtl/odo_cordic.sv =====
// ----------------------------------------------------------------------------
// odo_cordic - iterative rotation-mode CORDIC
// Folds the angle into plus or minus pi/2, then runs one micro-rotation per
// cycle through one pair of shifters. Cosine and sine come out in Q2.30.
// ----------------------------------------------------------------------------
module odo_cordic
  import odo_pkg::*;
#(
  parameter int STAGES = CORDIC_STAGES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [33:0] angle,
  output logic               busy,
  output logic               done,
  output logic signed [33:0] cos_out,
  output logic signed [33:0] sin_out
);

  localparam int CW = $clog2(STAGES + 1);

  logic signed [33:0] x, y, z;
  logic [CW-1:0]      cnt;
  logic               neg;
  logic signed [33:0] a1, a2;
  logic               fold;
  logic signed [33:0] dx, dy, at;

  always_comb begin
    if (angle > PI_Q29)       a1 = angle - TWO_PI_Q29;
    else if (angle < -PI_Q29) a1 = angle + TWO_PI_Q29;
    else                      a1 = angle;
    fold = 1'b1;
    if (a1 > HALF_PI_Q29)       a2 = a1 - PI_Q29;
    else if (a1 < -HALF_PI_Q29) a2 = a1 + PI_Q29;
    else begin
      a2   = a1;
      fold = 1'b0;
    end
  end

  assign dx = y >>> cnt;
  assign dy = x >>> cnt;
  assign at = atan_q30(5'(cnt));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !start && busy && (cnt == CW'(STAGES - 1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        x    <= CORDIC_GAIN;
        y    <= '0;
        z    <= a2 <<< 1;
        neg  <= fold;
      end else if (busy) begin
        if (!z[33]) begin
          x <= x - dx;
          y <= y + dy;
          z <= z - at;
        end else begin
          x <= x + dx;
          y <= y - dy;
          z <= z + at;
        end
        cnt <= cnt + CW'(1);
        if (cnt == CW'(STAGES - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign cos_out = neg ? -x : x;
  assign sin_out = neg ? -y : y;

endmodule

// ===== rtl/diff_drive_odometry_top.sv =====
// ----------------------------------------------------------------------------
// diff_drive_odometry_top - differential-drive wheel odometry
// Sequence: an arc update runs the CORDIC, the bit-serial divider twice and the
//   CORDIC again; a straight update runs the CORDIC once; set heading uses the
//   multiplier; other actions go straight to the result.
// Throughput: one request at a time; the next is taken once the result has
//   moved to the output register.
// Reset: synchronous; pose, history and registers go to defaults at once.
// ----------------------------------------------------------------------------
module diff_drive_odometry_top
  import odo_pkg::*;
#(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic         clk,
  input  logic         rst,
  // request channel
  input  logic         s_tvalid,
  output logic         s_tready,
  // [31:0] left_count, [63:32] right_count, [95:64] time_ms, [127:96] new_x,
  // [159:128] new_y, [185:160] new_heading_deg, [191:186] zero
  input  logic [191:0] s_tdata,
  // [2:0] action
  input  logic [2:0]   s_tuser,
  // result channel
  output logic         m_tvalid,
  input  logic         m_tready,
  // [31:0] pose_x, [63:32] pose_y, [95:64] heading
  output logic [95:0]  m_tdata,
  // [0] updated
  output logic [0:0]   m_tuser,
  // register writes
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  typedef enum logic [4:0] {
    S_IDLE, S_EXEC, S_TL, S_TR, S_C0, S_C0W, S_SX, S_SY, S_SF,
    S_RM, S_RD, S_RDW, S_DD, S_DDW, S_C1, S_C1W, S_AX, S_AY, S_AF,
    S_FIN, S_HD, S_HDF, S_DONE
  } state_t;

  state_t state;

  // configuration
  logic [22:0] track_width;
  logic [31:0] dist_tick;
  logic [15:0] min_ival;

  // persistent pose and history
  logic signed [31:0] pos_x, pos_y, head;
  logic [31:0]        prev_left, prev_right, prev_time;

  // latched request
  logic [2:0]         act;
  logic [31:0]        lc, rc, now;
  logic signed [31:0] nx, ny;
  logic signed [25:0] ndeg;

  // working registers
  logic signed [31:0] sl, sr, rad, dth;
  logic signed [33:0] c0, s0, c1, s1, th;
  logic               upd;

  // shared multiplier
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod;

  logic [22:0]        lw;
  logic signed [33:0] diff;
  logic [31:0]        since;

  // CORDIC and divider hookup
  logic               cdc_start, cdc_busy, cdc_done;
  logic signed [33:0] cdc_angle, cdc_cos, cdc_sin;
  logic               div_start, div_busy, div_done;
  logic signed [63:0] div_num;
  logic signed [35:0] div_den;
  logic signed [31:0] div_q;

  // rounded wheel travel and fixed-point helpers
  logic signed [31:0] trav;
  logic signed [31:0] step_x, step_y;
  logic signed [31:0] deg_rad;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == S_IDLE);

  // zero track width acts as one LSB
  assign lw    = (track_width == 23'd0) ? 23'd1 : track_width;
  assign diff  = 34'(sr) - 34'(sl);
  assign since = now - prev_time;

  assign trav    = sat32(68'((prod + 66'sd32768) >>> 16));
  assign deg_rad = sat32(68'((prod + 66'sd262144) >>> 19));
  assign step_x  = sat32(68'(pos_x) + 68'((prod + 66'sd536870912) >>> 30));
  assign step_y  = sat32(68'(pos_y) + 68'((prod + 66'sd536870912) >>> 30));

  // operand select for the one multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_TL: begin
        mul_a = 33'(signed'(lc - prev_left));
        mul_b = {1'b0, dist_tick};
      end
      S_TR: begin
        mul_a = 33'(signed'(rc - prev_right));
        mul_b = {1'b0, dist_tick};
      end
      S_SX: begin
        mul_a = 33'(sr);
        mul_b = c0[32:0];
      end
      S_SY: begin
        mul_a = 33'(sr);
        mul_b = s0[32:0];
      end
      S_RM: begin
        mul_a = {10'd0, lw};
        mul_b = 33'(sr) + 33'(sl);
      end
      S_AX: begin
        mul_a = 33'(rad);
        mul_b = 33'(s1 - s0);
      end
      S_AY: begin
        mul_a = 33'(rad);
        mul_b = 33'(c0 - c1);
      end
      S_HD: begin
        mul_a = 33'(ndeg);
        mul_b = DEG_TO_RAD;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // start the CORDIC at the old heading, then at the turned heading
  assign cdc_start = (state == S_C0) || (state == S_C1);
  assign cdc_angle = (state == S_C0) ? 34'(head) : 34'(head) + 34'(dth);

  // radius: l(sR+sL) / 2(sR-sL); heading change: (sR-sL)*2^29 / l
  assign div_start = (state == S_RD) || (state == S_DD);
  assign div_num   = (state == S_RD) ? prod[63:0] : 64'(diff) <<< 29;
  assign div_den   = (state == S_RD) ? 36'(diff) <<< 1 : {13'd0, lw};

  odo_cordic #(
    .STAGES (CORDIC_STAGES)
  ) u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (cdc_start),
    .angle   (cdc_angle),
    .busy    (cdc_busy),
    .done    (cdc_done),
    .cos_out (cdc_cos),
    .sin_out (cdc_sin)
  );

  odo_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      m_tvalid    <= 1'b0;
      track_width <= TRACK_WIDTH_RST;
      dist_tick   <= DIST_TICK_RST;
      min_ival    <= MIN_IVAL_RST;
      pos_x       <= '0;
      pos_y       <= '0;
      head        <= '0;
      prev_left   <= '0;
      prev_right  <= '0;
      prev_time   <= '0;
    end else begin
      // drop the result once it is taken, unless a new one replaces it
      if (m_tvalid && m_tready && (state != S_DONE)) m_tvalid <= 1'b0;

      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_TRACK_WIDTH: track_width <= cfg_data[22:0];
          CFG_DIST_TICK:   dist_tick   <= cfg_data;
          CFG_MIN_IVAL:    min_ival    <= cfg_data[15:0];
          default: ;
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            act   <= s_tuser;
            lc    <= s_tdata[31:0];
            rc    <= s_tdata[63:32];
            now   <= s_tdata[95:64];
            nx    <= s_tdata[127:96];
            ny    <= s_tdata[159:128];
            ndeg  <= s_tdata[185:160];
            upd   <= 1'b0;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          unique case (act)
            ACT_UPDATE: state <= (since >= 32'(min_ival)) ? S_TL : S_DONE;
            ACT_SET_XY: begin
              pos_x <= nx;
              pos_y <= ny;
              state <= S_DONE;
            end
            ACT_SET_HD: state <= S_HD;
            ACT_CLR_XY: begin
              pos_x <= '0;
              pos_y <= '0;
              state <= S_DONE;
            end
            ACT_INIT: begin
              pos_x     <= '0;
              pos_y     <= '0;
              head      <= '0;
              prev_time <= now;
              state     <= S_DONE;
            end
            ACT_RESTART: begin
              prev_time <= now;
              state     <= S_DONE;
            end
            default: state <= S_DONE;
          endcase
        end
        S_TL: state <= S_TR;
        S_TR: begin
          sl    <= trav;
          state <= S_C0;
        end
        S_C0: begin
          sr    <= trav;
          state <= S_C0W;
        end
        S_C0W: begin
          if (cdc_done) begin
            c0    <= cdc_cos;
            s0    <= cdc_sin;
            state <= (sl == sr) ? S_SX : S_RM;
          end
        end
        // straight run along the heading
        S_SX: state <= S_SY;
        S_SY: begin
          pos_x <= step_x;
          state <= S_SF;
        end
        S_SF: begin
          pos_y <= step_y;
          th    <= 34'(head);
          state <= S_FIN;
        end
        // arc
        S_RM: state <= S_RD;
        S_RD: state <= S_RDW;
        S_RDW: begin
          if (div_done) begin
            rad   <= div_q;
            state <= S_DD;
          end
        end
        S_DD: state <= S_DDW;
        S_DDW: begin
          if (div_done) begin
            dth   <= div_q;
            state <= S_C1;
          end
        end
        S_C1: state <= S_C1W;
        S_C1W: begin
          if (cdc_done) begin
            c1    <= cdc_cos;
            s1    <= cdc_sin;
            th    <= 34'(head) + 34'(dth);
            state <= S_AX;
          end
        end
        S_AX: state <= S_AY;
        S_AY: begin
          pos_x <= step_x;
          state <= S_AF;
        end
        S_AF: begin
          pos_y <= step_y;
          state <= S_FIN;
        end
        S_FIN: begin
          head       <= wrap_pi(th);
          prev_left  <= lc;
          prev_right <= rc;
          prev_time  <= now;
          upd        <= 1'b1;
          state      <= S_DONE;
        end
        S_HD: state <= S_HDF;
        S_HDF: begin
          head  <= deg_rad;
          state <= S_DONE;
        end
        S_DONE: begin
          // hold until the output register is free
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {head, pos_y, pos_x};
            m_tuser  <= upd;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // the CORDIC and the divider never run while a request can be taken
  a_units_idle: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !cdc_busy && !div_busy)
    else $error("arithmetic unit busy while idle");

  // the two iterative units never overlap
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(cdc_busy && div_busy))
    else $error("cordic and divider busy together");

  // after a pose update the heading lies within plus or minus pi
  a_head_wrapped: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |->
      $signed(m_tdata[95:64]) <= 32'sd1686629713 &&
      $signed(m_tdata[95:64]) >= -32'sd1686629713)
    else $error("heading not wrapped after update");

  // a result appears only when leaving the final state
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == S_DONE)
    else $error("result raised outside final state");

endmodule
